[rtl/core/gla_pkg.sv]
// gla_pkg: opcodes, status codes and result width for the GCD/LCM arithmetic unit.
// No dependencies.
`default_nettype none
package gla_pkg;
    localparam int RESULT_WIDTH = 62;
    localparam int STATUS_WIDTH = 2;
    localparam int OPC_WIDTH    = 3;

    localparam logic [OPC_WIDTH-1:0] OPC_ADD  = 3'd0;
    localparam logic [OPC_WIDTH-1:0] OPC_ABSD = 3'd1;
    localparam logic [OPC_WIDTH-1:0] OPC_MUL  = 3'd2;
    localparam logic [OPC_WIDTH-1:0] OPC_DIV  = 3'd3;
    localparam logic [OPC_WIDTH-1:0] OPC_LCM  = 3'd4;
    localparam logic [OPC_WIDTH-1:0] OPC_GCD  = 3'd5;

    localparam logic [STATUS_WIDTH-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_WIDTH-1:0] ST_DIV_ZERO = 2'd1;
    localparam logic [STATUS_WIDTH-1:0] ST_LCM_ZERO = 2'd2;

    // Saturated maximum of the result field
    localparam logic [RESULT_WIDTH-1:0] RESULT_MAX = {RESULT_WIDTH{1'b1}};
endpackage
`default_nettype wire

[rtl/core/gcd_lcm_arith_unit.sv]
// gcd_lcm_arith_unit: integer add/absdiff/mul/div/lcm/gcd with a shared divider.
// Depends on gla_pkg and gla_divider.
//
// channel | dir | fields (low bit first)
// s_axis  | in  | tdata: first_operand, second_operand, zero pad; tuser: req_type
// m_axis  | out | tdata: result_value, zero pad; tuser: status_code
//
// Add, absdiff, multiply: result computed in S_DISP and presented in S_OUT.
// Divide: one pass of the shared divider in S_DIV. GCD: one divider pass per
// Euclid step, the step count set by the operands; LCM adds one divide and a
// multiply step. After the output transfer the unit goes back to S_IDLE, where
// ready is raised again. Reset is synchronous, active low; not ready while an
// item is in work or while a result waits for m_axis_tready.
`default_nettype none
module gcd_lcm_arith_unit
    import gla_pkg::*;
#(
    parameter int OPERAND_WIDTH = 31
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic s_axis_tvalid,
    output logic      s_axis_tready,
    // first_operand, second_operand
    input  wire logic [((2*OPERAND_WIDTH+7)/8)*8-1:0] s_axis_tdata,
    // req_type
    input  wire logic [OPC_WIDTH-1:0] s_axis_tuser,
    output logic      m_axis_tvalid,
    input  wire logic m_axis_tready,
    // result_value
    output logic [63:0] m_axis_tdata,
    // status_code
    output logic [STATUS_WIDTH-1:0] m_axis_tuser
);
    localparam int W = OPERAND_WIDTH;
    localparam int PW = 2 * W;

    localparam logic [2:0] S_IDLE = 3'd0, S_DISP = 3'd1, S_DIV = 3'd2,
                           S_GCD = 3'd3, S_LDIV = 3'd4, S_MUL = 3'd5, S_OUT = 3'd6;

    logic [2:0]           r_st;
    logic [OPC_WIDTH-1:0] r_op;
    logic [W-1:0]         r_a, r_b, r_x, r_y;
    logic [RESULT_WIDTH-1:0] r_res;
    logic [STATUS_WIDTH-1:0] r_stat;
    logic                 r_dstart;
    logic                 w_done;
    logic [W-1:0]         w_quot, w_rem, w_big, w_small;
    logic [PW-1:0]        w_prod;
    logic [PW:0]          w_sum;

    assign w_big   = (r_a > r_b) ? r_a : r_b;
    assign w_small = (r_a > r_b) ? r_b : r_a;
    assign w_sum   = {1'b0, r_a} + {1'b0, r_b} + (PW+1)'(0);

    gla_divider #(.W(W)) u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(r_dstart),
        .i_dividend(r_x), .i_divisor(r_y),
        .o_done(w_done), .o_quot(w_quot), .o_rem(w_rem)
    );

    // one multiplier; in LCM r_x holds a/gcd
    assign w_prod = ((r_op == OPC_LCM) ? r_x : r_a) * r_b;

    function automatic logic [RESULT_WIDTH-1:0] sat(input logic [PW:0] v);
        if ((PW + 1) > RESULT_WIDTH && (v >> RESULT_WIDTH) != '0) return RESULT_MAX;
        return RESULT_WIDTH'(v);
    endfunction

    assign s_axis_tready = (r_st == S_IDLE);
    assign m_axis_tvalid = (r_st == S_OUT);
    assign m_axis_tdata  = {2'b00, r_res};
    assign m_axis_tuser  = r_stat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st     <= S_IDLE;
            r_dstart <= 1'b0;
        end else begin
            r_dstart <= 1'b0;
            case (r_st)
                S_IDLE: if (s_axis_tvalid) begin
                    r_op <= s_axis_tuser;
                    r_a  <= s_axis_tdata[W-1:0];
                    r_b  <= s_axis_tdata[2*W-1:W];
                    r_st <= S_DISP;
                end
                S_DISP: begin
                    r_stat <= ST_OK;
                    r_res  <= '0;
                    r_st   <= S_OUT;
                    case (r_op)
                        OPC_ADD:  r_res <= sat(w_sum);
                        OPC_ABSD: r_res <= RESULT_WIDTH'(w_big - w_small);
                        OPC_MUL:  r_res <= sat({1'b0, w_prod});
                        OPC_DIV: begin
                            if (w_small == '0) r_stat <= ST_DIV_ZERO;
                            else begin
                                r_x <= w_big; r_y <= w_small;
                                r_dstart <= 1'b1; r_st <= S_DIV;
                            end
                        end
                        OPC_LCM, OPC_GCD: begin
                            if (w_small == '0) begin
                                if (r_op == OPC_LCM) r_stat <= ST_LCM_ZERO;
                                else r_res <= RESULT_WIDTH'(1);
                            end else begin
                                r_x <= r_a; r_y <= r_b;
                                r_dstart <= 1'b1; r_st <= S_GCD;
                            end
                        end
                        default: ;
                    endcase
                end
                S_DIV: if (w_done) begin
                    r_res <= RESULT_WIDTH'(w_quot);
                    r_st  <= S_OUT;
                end
                // Euclid: x,y <- y, x mod y
                S_GCD: if (w_done) begin
                    if (w_rem == '0) begin
                        if (r_op == OPC_GCD) begin
                            r_res <= RESULT_WIDTH'(r_y);
                            r_st  <= S_OUT;
                        end else begin
                            r_x <= r_a; r_dstart <= 1'b1; r_st <= S_LDIV;
                        end
                    end else begin
                        r_x <= r_y; r_y <= w_rem; r_dstart <= 1'b1;
                    end
                end
                S_LDIV: if (w_done) begin
                    r_x  <= w_quot;
                    r_st <= S_MUL;
                end
                S_MUL: begin
                    r_res <= sat({1'b0, w_prod});
                    r_st  <= S_OUT;
                end
                S_OUT: if (m_axis_tready) r_st <= S_IDLE;
                default: r_st <= S_IDLE;
            endcase
        end
    end

    // error status always carries a zero result
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser != ST_OK |-> m_axis_tdata == '0)
        else $error("error result not zero");
    // divider only started from an operating state
    a_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_dstart |-> (r_st == S_DIV || r_st == S_GCD || r_st == S_LDIV))
        else $error("divider started out of sequence");
    // never ready while holding a result
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(s_axis_tready && m_axis_tvalid))
        else $error("ready while result pending");
endmodule
`default_nettype wire

[rtl/core/gla_divider.sv]
// gla_divider: restoring bit-serial divider, one quotient bit per cycle.
// Depends on nothing but its parameter; used by gcd_lcm_arith_unit.
`default_nettype none
module gla_divider #(
    parameter int W = 31
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_start,
    input  wire logic [W-1:0] i_dividend,
    input  wire logic [W-1:0] i_divisor,
    output logic              o_done,
    output logic [W-1:0]      o_quot,
    output logic [W-1:0]      o_rem
);
    localparam int CW = $clog2(W + 1);

    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic [W-1:0]  r_q, r_d;
    logic [W:0]    r_r;
    logic [W:0]    w_sh;
    logic [W:0]    w_diff;

    // shift in next dividend bit and trial subtract
    assign w_sh   = {r_r[W-1:0], r_q[W-1]};
    assign w_diff = w_sh - {1'b0, r_d};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q <= i_dividend;
            r_d <= i_divisor;
            r_r <= '0;
        end else if (r_busy) begin
            if (!w_diff[W]) begin
                r_r <= w_diff;
                r_q <= {r_q[W-2:0], 1'b1};
            end else begin
                r_r <= w_sh;
                r_q <= {r_q[W-2:0], 1'b0};
            end
        end
    end

    assign o_quot = r_q;
    assign o_rem  = r_r[W-1:0];
endmodule
`default_nettype wire
